// File: rtl/abaf_pkg.sv
// abaf_pkg: shared types and constants of the arena bump allocator
// operation and status codes, item structs, fixed sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package abaf_pkg;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned SizeW   = 17;
  localparam int unsigned AlignW  = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned PtrW    = 17;
  localparam int unsigned CountW  = 32;
  localparam int unsigned DepthW  = 5;

  // built arena size and frame stack size
  localparam logic [32:0] ArenaBytes = 33'd65536;
  localparam int unsigned MaxFrames  = 16;
  localparam int unsigned FrameIdxW  = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam logic [DepthW-1:0] MaxFramesD = DepthW'(MaxFrames);

  // configuration port
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [PaddrW-1:0] RegCapacityAddr = 3'd0;
  localparam logic [PtrW-1:0]   CapacityReset   = 17'd65536;

  typedef enum logic [OpW-1:0] {
    OpAlloc      = 2'd0,
    OpBeginFrame = 2'd1,
    OpEndFrame   = 2'd2,
    OpResetArena = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StNoRoom     = 3'd1,
    StStackFull  = 3'd2,
    StStackEmpty = 3'd3,
    StZeroSize   = 3'd4
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [SizeW-1:0]  size;
    logic [AlignW-1:0] align_log2;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [OffsetW-1:0] offset;
    logic [PtrW-1:0]    used;
    logic [PtrW-1:0]    peak_used;
    logic [CountW-1:0]  alloc_count;
    logic [CountW-1:0]  total_bytes;
    logic [DepthW-1:0]  depth;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/arena_bump_allocator_frames.sv
// arena_bump_allocator_frames: bump allocator with a mark/release frame stack
// results are registered; a successful end frame first reads its mark from the mark ram
// throughput: one transaction per cycle while the output is not stalled, except a
//   successful end frame, which holds the input while the mark is read back
// reset: pointer, depth, peak, counters cleared, capacity 65536; stack ram not cleared
// depends on abaf_pkg, abaf_ram
`timescale 1ns / 1ps
`default_nettype none

module arena_bump_allocator_frames
  import abaf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire req_t              in_data_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rsp_t                   out_data_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  // one-hot control: idle takes a transaction, pop waits for the mark
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StPop  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // scalar allocator state
  logic [PtrW-1:0]   cap_q;
  logic [PtrW-1:0]   bump_q, bump_d;
  logic [PtrW-1:0]   peak_q, peak_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] total_q, total_d;

  // output register
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;
  logic load_out;

  // frame stack ram
  logic                 ram_we, ram_re;
  logic [FrameIdxW-1:0] ram_waddr, ram_raddr;
  logic [PtrW-1:0]      ram_rdata;

  logic              in_acc;
  logic [DepthW-1:0] depth_dec;
  logic [StatusW-1:0] res_status;
  logic [OffsetW-1:0] res_offset;

  // ---------------------------------------------------------------------------
  // configuration: capacity register, written from the apb port
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == RegCapacityAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[PtrW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegCapacityAddr) begin
      prdata = {{(PdataW-PtrW){1'b0}}, cap_q};
    end
  end

  // ---------------------------------------------------------------------------
  // allocate datapath: align, add, compare against effective capacity
  // ---------------------------------------------------------------------------
  logic [PtrW-1:0]  eff_cap;
  logic [OffsetW-1:0] align_mask;
  logic [PtrW:0]    aligned;      // pointer plus mask can exceed 17 bits
  logic [PtrW+1:0]  need;         // aligned end of the block
  logic             fits;
  logic [CountW:0]  total_sum;

  // the register may name more than the built arena
  assign eff_cap = ({16'd0, cap_q} > ArenaBytes) ? ArenaBytes[PtrW-1:0] : cap_q;

  assign align_mask = OffsetW'((17'd1 << in_data_i.align_log2) - 17'd1);
  assign aligned    = ({1'b0, bump_q} + {2'b00, align_mask}) & ~{2'b00, align_mask};
  assign need       = {1'b0, aligned} + {2'b00, in_data_i.size};
  assign fits       = need <= {2'b00, eff_cap};
  assign total_sum  = {1'b0, total_q} + {{(CountW+1-SizeW){1'b0}}, in_data_i.size};

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  // output slot free or draining this cycle, and no pop in flight
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign depth_dec  = depth_q - DepthW'(1);

  // a push writes at its edge and a later pop reads only at a later edge,
  // so one transaction at a time never sees a read-write overlap
  assign ram_waddr = depth_q[FrameIdxW-1:0];
  assign ram_raddr = depth_dec[FrameIdxW-1:0];

  always_comb begin
    state_d    = state_q;
    bump_d     = bump_q;
    peak_d     = peak_q;
    depth_d    = depth_q;
    count_d    = count_q;
    total_d    = total_q;
    res_status = StOk;
    res_offset = '0;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          load_out = 1'b1;
          unique case (op_e'(in_data_i.op))
            OpAlloc: begin
              if (in_data_i.size == '0) begin
                res_status = StZeroSize;
              end else if (!fits) begin
                res_status = StNoRoom;
              end else begin
                res_offset = aligned[OffsetW-1:0];
                bump_d     = need[PtrW-1:0];
                if (count_q != '1) begin
                  count_d = count_q + CountW'(1);
                end
                total_d = total_sum[CountW] ? '1 : total_sum[CountW-1:0];
                if (need[PtrW-1:0] > peak_q) begin
                  peak_d = need[PtrW-1:0];
                end
              end
            end
            OpBeginFrame: begin
              if (depth_q >= MaxFramesD) begin
                res_status = StStackFull;
              end else begin
                ram_we  = 1'b1;
                depth_d = depth_q + DepthW'(1);
              end
            end
            OpEndFrame: begin
              if (depth_q == '0) begin
                res_status = StStackEmpty;
              end else begin
                // mark arrives next cycle, result is registered then
                ram_re   = 1'b1;
                depth_d  = depth_dec;
                load_out = 1'b0;
                state_d  = StPop;
              end
            end
            OpResetArena: begin
              bump_d  = '0;
              depth_d = '0;
              count_d = '0;
            end
          endcase
        end
      end
      StPop: begin
        bump_d   = ram_rdata;
        load_out = 1'b1;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // the result shows the state after the transaction
    out_d.status      = res_status;
    out_d.offset      = res_offset;
    out_d.used        = bump_d;
    out_d.peak_used   = peak_d;
    out_d.alloc_count = count_d;
    out_d.total_bytes = total_d;
    out_d.depth       = depth_d;

    out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bump_q      <= '0;
      peak_q      <= '0;
      depth_q     <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      peak_q      <= peak_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // frame mark stack
  // ---------------------------------------------------------------------------
  abaf_ram #(
    .Width(PtrW),
    .Depth(MaxFrames)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(bump_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // stack depth never passes the built stack
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MaxFramesD)
    else $error("frame depth above stack size");

  // a pop result always finds the output slot empty
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPop) |-> !out_valid_q)
    else $error("pop completes into an occupied output slot");

  // pointer never rises above the recorded peak
  a_bump_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= peak_q)
    else $error("bump pointer above peak");

  // zero-size allocate reports its error on the next cycle
  a_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.op == OpAlloc) && (in_data_i.size == '0)) |=>
      (out_valid_q && (out_q.status == StZeroSize)))
    else $error("zero-size allocate not reported");

endmodule

`default_nettype wire

// File: rtl/abaf_ram.sv
// abaf_ram: generic single-write, single-read synchronous ram
// one write port, one read port with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module abaf_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
